// ----- rtl/dttb_pkg.sv -----
// ----------------------------------------------------------------------------
// dttb_pkg
// Shared types and constants for the decode time table builder.
// ----------------------------------------------------------------------------
package dttb_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int PTS_W      = 48;
    localparam int DUR_W      = 32;
    localparam int DEF_W      = 31;
    localparam int PIC_W      = 6;
    localparam int CMP_W      = PIC_W + 1;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_ADDR,
        S_LO,
        S_HI
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;         // store one frame entry
        logic fin_start;    // clear entry index and decode time
        logic ord_rd;       // read order store
        logic ord_next;     // order read at index + 1
        logic time_rd;      // read time store
        logic time_new;     // time read at a freshly chosen slot, else slot + 1
        logic ent_next;     // slot choice refers to the next entry
        logic latch_t0;     // capture time of current slot
        logic emit;         // load output register, advance entry
        logic clear;        // end of finish: drop frame count and reorder flag
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic last_entry;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/dttb_ram.sv -----
// ----------------------------------------------------------------------------
// dttb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/dttb_ctrl.sv -----
// ----------------------------------------------------------------------------
// dttb_ctrl
// Sequencer: accepts loads and finish, walks stored frames on finish.
// ----------------------------------------------------------------------------
module dttb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_operation,
    output logic              o_in_ready,
    input  dttb_pkg::t_status i_status,
    output dttb_pkg::t_cmd    o_cmd
);

    import dttb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_status.count_zero) begin
                        o_cmd.fin_start = 1'b1;
                        o_cmd.clear     = 1'b1;
                    end else begin
                        o_cmd.fin_start = 1'b1;
                        n_state         = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                o_cmd.ord_rd = 1'b1;
                n_state      = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.time_rd  = 1'b1;
                o_cmd.time_new = 1'b1;
                n_state        = S_LO;
            end
            S_LO: begin
                o_cmd.latch_t0 = 1'b1;
                o_cmd.time_rd  = 1'b1;
                o_cmd.ord_rd   = 1'b1;
                o_cmd.ord_next = 1'b1;
                n_state        = S_HI;
            end
            S_HI: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_entry) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.time_rd  = 1'b1;
                        o_cmd.time_new = 1'b1;
                        o_cmd.ent_next = 1'b1;
                        n_state        = S_LO;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/dttb_dpath.sv -----
// ----------------------------------------------------------------------------
// dttb_dpath
// Frame stores, counters, duration/offset arithmetic and output register.
// ----------------------------------------------------------------------------
module dttb_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dttb_pkg::t_cmd                i_cmd,
    output dttb_pkg::t_status             o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [dttb_pkg::DEF_W-1:0]    i_cfg_wr_data,
    input  logic [dttb_pkg::PTS_W-1:0]    i_pts,
    input  logic [dttb_pkg::DUR_W-1:0]    i_frame_duration,
    input  logic [dttb_pkg::PIC_W-1:0]    i_picture_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dttb_pkg::DUR_W-1:0]    o_decode_duration,
    output logic [dttb_pkg::DUR_W-1:0]    o_composition_offset,
    output logic                          o_reordered,
    output logic                          o_last_entry
);

    import dttb_pkg::*;

    // Only the low DUR_W bits of any time reach a result, so times are kept
    // at that width; 48-bit wrap does not affect them.
    logic [CNT_W-1:0] r_count;
    logic [DUR_W-1:0] r_end;
    logic [PIC_W-1:0] r_last_pic;
    logic             r_reord;
    logic [DEF_W-1:0] r_default;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_p;
    logic [DUR_W-1:0] r_t0;
    logic [DUR_W-1:0] r_dt;
    logic             r_out_valid;
    logic [DUR_W-1:0] r_out_dur;
    logic [DUR_W-1:0] r_out_ofs;
    logic             r_out_reord;
    logic             r_out_last;

    logic             full;
    logic             load_do;
    logic             pic_break;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] ent;
    logic [IDX_W-1:0] clamped;
    logic [IDX_W-1:0] p_next;
    logic [IDX_W-1:0] ord_addr;
    logic [IDX_W-1:0] time_addr;
    logic [PIC_W-1:0] ord_q;
    logic [DUR_W-1:0] time_q;
    logic             p_last;
    logic [DUR_W-1:0] diff;
    logic [DUR_W-1:0] dur;
    logic [DUR_W-1:0] ofs;

    assign full      = (r_count == CNT_W'(MAX_FRAMES));
    assign load_do   = i_cmd.load && !full;
    assign pic_break = ({1'b0, r_last_pic} + CMP_W'(1)) != {1'b0, i_picture_number};
    assign last_idx  = IDX_W'(r_count - CNT_W'(1));

    assign ord_addr  = i_cmd.ord_next ? (r_idx + IDX_W'(1)) : r_idx;
    assign ent       = i_cmd.ent_next ? (r_idx + IDX_W'(1)) : r_idx;
    // picture number at or above the frame count maps to the last frame
    assign clamped   = ({1'b0, ord_q} >= CMP_W'(r_count)) ? last_idx
                                                           : IDX_W'(ord_q);
    assign p_next    = r_reord ? clamped : ent;
    assign time_addr = i_cmd.time_new ? p_next : (r_p + IDX_W'(1));

    assign p_last = (r_p == last_idx);
    assign diff   = (p_last ? r_end : time_q) - r_t0;
    assign dur    = (p_last && ((diff == '0) || diff[DUR_W-1])) ? {1'b0, r_default} : diff;
    assign ofs    = r_reord ? (r_t0 - r_dt) : '0;

    dttb_ram #(
        .WIDTH (DUR_W),
        .DEPTH (MAX_FRAMES)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_we      (load_do),
        .i_wr_addr (IDX_W'(r_count)),
        .i_wr_data (i_pts[DUR_W-1:0]),
        .i_rd_en   (i_cmd.time_rd),
        .i_rd_addr (time_addr),
        .o_rd_data (time_q)
    );

    dttb_ram #(
        .WIDTH (PIC_W),
        .DEPTH (MAX_FRAMES)
    ) u_order_ram (
        .i_clk     (i_clk),
        .i_we      (load_do),
        .i_wr_addr (IDX_W'(r_count)),
        .i_wr_data (i_picture_number),
        .i_rd_en   (i_cmd.ord_rd),
        .i_rd_addr (ord_addr),
        .o_rd_data (ord_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_reord     <= 1'b0;
            r_default   <= DEF_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_default <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_reord <= 1'b0;
            end else if (load_do) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count != '0 && pic_break) begin
                    r_reord <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // end time reset value is never observed: finish needs at least one load
    always_ff @(posedge i_clk) begin
        if (load_do) begin
            r_end      <= i_pts[DUR_W-1:0] + i_frame_duration;
            r_last_pic <= i_picture_number;
        end
        if (i_cmd.fin_start) begin
            r_idx <= '0;
            r_dt  <= '0;
        end
        if (i_cmd.time_rd && i_cmd.time_new) begin
            r_p <= p_next;
        end
        if (i_cmd.latch_t0) begin
            r_t0 <= time_q;
        end
        if (i_cmd.emit) begin
            r_idx       <= r_idx + IDX_W'(1);
            r_dt        <= r_dt + dur;
            r_out_dur   <= dur;
            r_out_ofs   <= ofs;
            r_out_reord <= r_reord;
            r_out_last  <= (r_idx == last_idx);
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.last_entry = (r_idx == last_idx);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid          = r_out_valid;
    assign o_decode_duration    = r_out_dur;
    assign o_composition_offset = r_out_ofs;
    assign o_reordered          = r_out_reord;
    assign o_last_entry         = r_out_last;

endmodule

// ----- rtl/decode_time_table_builder_top.sv -----
// ----------------------------------------------------------------------------
// decode_time_table_builder_top
// Builds per-frame decode-duration and composition-offset tables from loaded
// presentation times and display-order picture numbers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  ---------------------------------
// in        input      i_in_valid/o_in_ready   operation, pts, frame_duration,
//                                              picture_number
// out       output     o_out_valid/i_out_ready decode_duration, composition_offset,
//                                              reordered, last_entry
// cfg       input      i_cfg_wr_en             fallback duration (no wait)
//
// A finish walks the stored frames. When the output side never stalls,
// two reads of the time store per entry (its slot and the slot after it)
// set the pace, with order store reads overlapped.
// A stalled output holds the walk in place; the input side is not ready
// until the last entry has gone into the output register.
// Reset (synchronous, active low) clears frame count, reorder flag, output
// valid and the fallback duration (to 1). The frame stores need no clearing.
// ----------------------------------------------------------------------------
module decode_time_table_builder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [dttb_pkg::DEF_W-1:0]    i_cfg_wr_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [dttb_pkg::PTS_W-1:0]    i_pts,
    input  logic [dttb_pkg::DUR_W-1:0]    i_frame_duration,
    input  logic [dttb_pkg::PIC_W-1:0]    i_picture_number,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dttb_pkg::DUR_W-1:0]    o_decode_duration,
    output logic [dttb_pkg::DUR_W-1:0]    o_composition_offset,
    output logic                          o_reordered,
    output logic                          o_last_entry
);

    import dttb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: idle/load, then prime order read, pick slot, and a
    // two-state loop per entry (time of slot, time of next slot + emit)
    dttb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // stores, reorder detection (tracked during loads), arithmetic and the
    // output register that lets the walk continue while a result waits
    dttb_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_pts                (i_pts),
        .i_frame_duration     (i_frame_duration),
        .i_picture_number     (i_picture_number),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_decode_duration    (o_decode_duration),
        .o_composition_offset (o_composition_offset),
        .o_reordered          (o_reordered),
        .o_last_entry         (o_last_entry)
    );

endmodule
